// ===== hdl/xdb_pkg.sv =====
package xdb_pkg;
    localparam int BucketSizeDef  = 16;
    localparam int BucketCountDef = 256;
    localparam int IdW            = 64;
    localparam int BktW           = 8;
    localparam int MaxBucket      = 255;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SET    = 2'd2,
        OP_GET    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_FULL    = 2'd2,
        ST_ABSENT  = 2'd3
    } t_status;

    // classified beat handed from front to back
    typedef struct packed {
        t_op            op;
        logic [255:0]   id;
        logic [63:0]    time_value;
        logic [BktW-1:0] bucket;
    } t_cmd;

    // leading zero count of a 64-bit word, capped at 64
    function automatic logic [6:0] lzc64(input logic [63:0] v);
        logic [6:0] n;
        logic       hit;
        n   = 7'd0;
        hit = 1'b0;
        for (int b = 63; b >= 0; b--) begin
            if (!hit && v[b]) begin
                hit = 1'b1;
            end else if (!hit) begin
                n = n + 7'd1;
            end
        end
        return n;
    endfunction
endpackage

// ===== hdl/xdb_ram.sv =====
module xdb_ram #(
    parameter int W = 64,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
    end
    assign o_rdata = r_rd;
endmodule

// ===== hdl/xdb_front.sv =====
// Takes a start beat, computes the bucket (registered word lzc, then sum)
// and pushes the classified command into a two-entry queue.
module xdb_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_addr,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_start,
    input  xdb_pkg::t_op       i_operation,
    input  logic [255:0]       i_id,
    input  logic [63:0]        i_time_value,
    output logic               o_busy,
    input  logic               i_pop,
    output logic               o_q_valid,
    output xdb_pkg::t_cmd      o_q_cmd
);
    import xdb_pkg::*;

    logic [63:0] r_own [4];
    logic        r_s1_v;
    t_op         r_s1_op;
    logic [255:0] r_s1_id;
    logic [63:0] r_s1_tv;
    logic [3:0]  r_s1_nz;
    logic [6:0]  r_s1_lz [4];
    t_cmd        r_q [2];
    logic [1:0]  r_q_cnt;
    logic        r_q_wp, r_q_rp;

    logic [8:0]  n_sum;
    t_cmd        n_cmd;
    logic        push;

    // one item in flight at a time: hold off while anything is pending
    assign o_busy    = r_s1_v || (r_q_cnt != 2'd0);
    assign o_q_valid = (r_q_cnt != 2'd0);
    assign o_q_cmd   = r_q[r_q_rp];
    assign push      = r_s1_v;

    always_comb begin
        if (r_s1_nz[0]) begin
            n_sum = {2'b0, r_s1_lz[0]};
        end else if (r_s1_nz[1]) begin
            n_sum = 9'd64 + {2'b0, r_s1_lz[1]};
        end else if (r_s1_nz[2]) begin
            n_sum = 9'd128 + {2'b0, r_s1_lz[2]};
        end else if (r_s1_nz[3]) begin
            n_sum = 9'd192 + {2'b0, r_s1_lz[3]};
        end else begin
            n_sum = 9'(MaxBucket);
        end
        if (n_sum > 9'(MaxBucket)) begin
            n_sum = 9'(MaxBucket);
        end
        n_cmd.op         = r_s1_op;
        n_cmd.id         = r_s1_id;
        n_cmd.time_value = r_s1_tv;
        n_cmd.bucket     = n_sum[BktW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_own[k] <= '0;
            end
            r_s1_v  <= 1'b0;
            r_q_cnt <= '0;
            r_q_wp  <= 1'b0;
            r_q_rp  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_own[i_cfg_addr] <= i_cfg_data;
            end
            r_s1_v <= i_start && !o_busy;
            if (push) begin
                r_q[r_q_wp] <= n_cmd;
                r_q_wp      <= !r_q_wp;
            end
            if (i_pop) begin
                r_q_rp <= !r_q_rp;
            end
            r_q_cnt <= r_q_cnt + {1'b0, push} - {1'b0, i_pop};
        end
        if (i_start && !o_busy) begin
            r_s1_op <= i_operation;
            r_s1_id <= i_id;
            r_s1_tv <= i_time_value;
            for (int k = 0; k < 4; k++) begin
                r_s1_nz[k] <= |(i_id[255-64*k -: 64] ^ r_own[k]);
                r_s1_lz[k] <= lzc64(i_id[255-64*k -: 64] ^ r_own[k]);
            end
        end
    end
endmodule

// ===== hdl/xdb_back.sv =====
// Executes one command: scans the bucket slot by slot (one ID word per cycle
// from the ID RAM, a compare step after each slot), then writes, swaps or reads time.
module xdb_back #(
    parameter int SLOTS_PER_BKT = xdb_pkg::BucketSizeDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  xdb_pkg::t_cmd      i_q_cmd,
    output logic               o_pop,
    output logic               o_valid,
    output xdb_pkg::t_status   o_status,
    output logic [7:0]         o_bucket_index,
    output logic [63:0]        o_last_time,
    output logic [4:0]         o_bucket_fill
);
    import xdb_pkg::*;

    localparam int SW  = (SLOTS_PER_BKT > 1) ? $clog2(SLOTS_PER_BKT) : 1;
    localparam int CW  = $clog2(SLOTS_PER_BKT + 1);
    localparam int TD  = 256 * SLOTS_PER_BKT;
    localparam int TAW = $clog2(TD);
    localparam int ID  = TD * 4;
    localparam int IAW = $clog2(ID);

    typedef enum logic [3:0] {
        S_IDLE, S_CNT, S_RD, S_CMP, S_DECIDE, S_ADDW, S_MVRD, S_MVWAIT,
        S_MVW, S_TRD, S_TWAIT, S_OUT, S_CLR, S_CLD
    } t_state;

    t_state      r_st;
    t_cmd        r_cmd;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_slot;
    logic [1:0]  r_word;
    logic [1:0]  r_cword;
    logic        r_match;
    logic        r_found;
    logic [SW-1:0] r_fslot;
    logic        r_cmp_v;
    t_status     r_status;
    logic [63:0] r_time;
    logic [CW-1:0] r_fill;
    logic        r_valid;
    logic [7:0]  r_clr;

    logic          id_we;
    logic [IAW-1:0] id_wa, id_ra;
    logic [63:0]   id_wd, id_rd;
    logic          t_we;
    logic [TAW-1:0] t_wa, t_ra;
    logic [63:0]   t_wd, t_rd;
    logic          cnt_we;
    logic [7:0]    cnt_wa, cnt_ra;
    logic [CW-1:0] cnt_wd, cnt_rd;
    logic [SW-1:0] last_slot;

    assign last_slot = SW'(r_cnt - CW'(1));

    xdb_ram #(.W(64), .D(ID)) u_id (
        .i_clk, .i_we(id_we), .i_waddr(id_wa), .i_wdata(id_wd),
        .i_raddr(id_ra), .o_rdata(id_rd)
    );
    xdb_ram #(.W(64), .D(TD)) u_time (
        .i_clk, .i_we(t_we), .i_waddr(t_wa), .i_wdata(t_wd),
        .i_raddr(t_ra), .o_rdata(t_rd)
    );
    // per-bucket entry counts
    xdb_ram #(.W(CW), .D(256)) u_cnt (
        .i_clk, .i_we(cnt_we), .i_waddr(cnt_wa), .i_wdata(cnt_wd),
        .i_raddr(cnt_ra), .o_rdata(cnt_rd)
    );

    function automatic logic [IAW-1:0] ida(input logic [7:0] b,
                                            input logic [SW-1:0] s,
                                            input logic [1:0] w);
        return IAW'((({24'd0, b} * SLOTS_PER_BKT + {{(32-SW){1'b0}}, s}) * 4)
                    + {30'd0, w});
    endfunction

    always_comb begin
        id_we  = 1'b0;
        id_wa  = ida(r_cmd.bucket, r_slot, r_word);
        id_wd  = r_cmd.id[255-64*r_word -: 64];
        id_ra  = ida(r_cmd.bucket, r_slot, r_word);
        t_we   = 1'b0;
        t_wa   = TAW'({24'd0, r_cmd.bucket} * SLOTS_PER_BKT
                      + {{(32-SW){1'b0}}, r_fslot});
        t_wd   = r_cmd.time_value;
        t_ra   = TAW'({24'd0, r_cmd.bucket} * SLOTS_PER_BKT
                      + {{(32-SW){1'b0}}, last_slot});
        cnt_we = 1'b0;
        cnt_wa = r_cmd.bucket;
        cnt_wd = r_cnt + CW'(1);
        cnt_ra = r_cmd.bucket;
        case (r_st)
            S_CLR: begin
                cnt_we = 1'b1;
                cnt_wa = r_clr;
                cnt_wd = '0;
            end
            S_ADDW: begin
                id_we = 1'b1;
                id_wa = ida(r_cmd.bucket, SW'(r_cnt), r_word);
                if (r_word == 2'd0) begin
                    t_we = 1'b1;
                    t_wa = TAW'({24'd0, r_cmd.bucket} * SLOTS_PER_BKT
                                + {{(32-CW){1'b0}}, r_cnt});
                    t_wd = '0;
                end
                cnt_we = (r_word == 2'd3);
            end
            // hold the last-slot address until the data is written
            S_MVRD, S_MVWAIT: begin
                id_ra = ida(r_cmd.bucket, last_slot, r_word);
            end
            S_MVW: begin
                id_we = 1'b1;
                id_wa = ida(r_cmd.bucket, r_fslot, r_word);
                id_wd = id_rd;
                if (r_word == 2'd0) begin
                    t_we = 1'b1;
                    t_wd = t_rd;
                end
                cnt_we = (r_word == 2'd3);
                cnt_wd = r_cnt - CW'(1);
            end
            S_DECIDE: begin
                t_we = (r_cmd.op == OP_SET) && r_found;
            end
            S_TRD: begin
                t_ra = TAW'({24'd0, r_cmd.bucket} * SLOTS_PER_BKT
                            + {{(32-SW){1'b0}}, r_fslot});
            end
            default: ;
        endcase
    end

    assign o_pop          = (r_st == S_IDLE) && i_q_valid;
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_bucket_index = r_cmd.bucket;
    assign o_last_time    = r_time;
    assign o_bucket_fill  = 5'(r_fill);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_CLR;
            r_valid <= 1'b0;
            r_clr   <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + 8'd1;
                    if (r_clr == 8'hFF) begin
                        r_st <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd <= i_q_cmd;
                        r_st  <= S_CNT;
                    end
                end
                S_CNT: r_st <= S_CLD;
                S_CLD: begin
                    r_cnt   <= cnt_rd;
                    r_slot  <= '0;
                    r_word  <= '0;
                    r_found <= 1'b0;
                    r_cmp_v <= 1'b0;
                    r_match <= 1'b1;
                    r_st    <= (cnt_rd == '0) ? S_DECIDE : S_RD;
                end
                S_RD: begin
                    // issue reads; data returns next cycle, last word checked in S_CMP
                    r_cword <= r_word;
                    r_cmp_v <= 1'b1;
                    r_word  <= r_word + 2'd1;
                    if (r_cmp_v) begin
                        r_match <= r_match && (id_rd == r_cmd.id[255-64*r_cword -: 64]);
                    end
                    if (r_word == 2'd3) begin
                        r_st <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (r_match && (id_rd == r_cmd.id[255-64*r_cword -: 64])) begin
                        r_found <= 1'b1;
                        r_fslot <= r_slot;
                        r_st    <= S_DECIDE;
                    end else if (CW'(r_slot) + CW'(1) >= r_cnt) begin
                        r_st <= S_DECIDE;
                    end else begin
                        r_slot  <= r_slot + SW'(1);
                        r_match <= 1'b1;
                        r_cmp_v <= 1'b0;
                        r_st    <= S_RD;
                    end
                end
                S_DECIDE: begin
                    r_word   <= '0;
                    r_time   <= '0;
                    r_fill   <= r_cnt;
                    r_status <= ST_DONE;
                    r_st     <= S_OUT;
                    case (r_cmd.op)
                        OP_ADD: begin
                            if (r_found) begin
                                r_status <= ST_PRESENT;
                            end else if (r_cnt < CW'(SLOTS_PER_BKT)) begin
                                r_st <= S_ADDW;
                            end else begin
                                r_status <= ST_FULL;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_found) begin
                                r_st <= S_MVRD;
                            end else begin
                                r_status <= ST_ABSENT;
                            end
                        end
                        OP_SET: begin
                            if (!r_found) begin
                                r_status <= ST_ABSENT;
                            end
                        end
                        default: begin
                            if (r_found) begin
                                r_st <= S_TRD;
                            end else begin
                                r_status <= ST_ABSENT;
                                r_time   <= '1;
                            end
                        end
                    endcase
                end
                S_ADDW: begin
                    r_word <= r_word + 2'd1;
                    if (r_word == 2'd3) begin
                        r_fill <= r_cnt + CW'(1);
                        r_st   <= S_OUT;
                    end
                end
                S_MVRD: r_st <= S_MVWAIT;
                S_MVWAIT: r_st <= S_MVW;
                S_MVW: begin
                    r_word <= r_word + 2'd1;
                    if (r_word == 2'd3) begin
                        r_fill <= r_cnt - CW'(1);
                        r_st   <= S_OUT;
                    end else begin
                        r_st <= S_MVRD;
                    end
                end
                S_TRD: r_st <= S_TWAIT;
                S_TWAIT: begin
                    r_time <= t_rd;
                    r_st   <= S_OUT;
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    r_st    <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hdl/xor_distance_bucket_table.sv =====
// XOR-distance bucket table.
// Channels: a start/busy command input (operation, 256-bit ID, time value)
// and a result strobe o_done with status, bucket index, time and fill.
// An input beat is taken when i_start is high and o_busy is low; o_busy
// stays high until its result has been shown, so one command runs at a time.
// The user must write the own ID through i_cfg_we/i_cfg_addr/i_cfg_data
// only while idle; the block does not enforce this. A command scans its
// bucket, then an add writes the entry, a set its time, a remove swaps in
// the last entry (read, wait, write per ID word), a get reads the time.
// The scan reads one ID word a cycle from the ID RAM, with a compare step
// after each slot. The next beat can be taken the cycle after the strobe.
// Reset clears the own ID at once and starts a clearing pass over all 256
// bucket counts; a command taken during it waits in the queue. Stored
// entries are never cleared and are read only below the count.
// Results hold for one cycle; the receiver cannot stall them.
module xor_distance_bucket_table #(
    parameter int SLOTS_PER_BKT = xdb_pkg::BucketSizeDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [63:0] i_cfg_data,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_id_word_0,
    input  logic [63:0] i_id_word_1,
    input  logic [63:0] i_id_word_2,
    input  logic [63:0] i_id_word_3,
    input  logic [63:0] i_time_value,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [7:0]  o_bucket_index,
    output logic [63:0] o_last_time,
    output logic [4:0]  o_bucket_fill
);
    import xdb_pkg::*;

    logic    q_valid, pop, front_busy, r_run;
    t_cmd    q_cmd;
    t_status st;

    xdb_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_addr, .i_cfg_data,
        .i_start(i_start && !o_busy), .i_operation(t_op'(i_operation)),
        .i_id({i_id_word_0, i_id_word_1, i_id_word_2, i_id_word_3}),
        .i_time_value, .o_busy(front_busy), .i_pop(pop),
        .o_q_valid(q_valid), .o_q_cmd(q_cmd)
    );

    xdb_back #(.SLOTS_PER_BKT(SLOTS_PER_BKT)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_cmd(q_cmd), .o_pop(pop),
        .o_valid(o_done), .o_status(st), .o_bucket_index, .o_last_time,
        .o_bucket_fill
    );

    // busy from accept until the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_start && !o_busy) begin
            r_run <= 1'b1;
        end else if (o_done) begin
            r_run <= 1'b0;
        end
    end
    assign o_busy   = r_run || front_busy;
    assign o_status = st;
endmodule

// ===== hdl/xdb_checker.sv =====
module xdb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_done,
    input logic [1:0] o_status,
    input logic [4:0] o_bucket_fill
);
    import xdb_pkg::*;

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("busy not raised");
    a_done_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy) else $error("result without command");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result longer than a cycle");
    a_full_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_FULL) |-> (o_bucket_fill != 5'd0))
        else $error("full with empty bucket");
endmodule

bind xor_distance_bucket_table xdb_checker u_chk (
    .i_clk, .i_rst_n, .i_start, .o_busy, .o_done, .o_status, .o_bucket_fill
);
